>>> hw/rtl/ltc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_pkg
// shared types and fixed field widths for the lru tag cache
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int unsigned KEY_IN_BITS = 32;
  localparam int unsigned HANDLE_BITS = 32;
  localparam int unsigned SLOT_BITS   = 3;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/ltc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ltc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/lru_tag_cache_8way.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_tag_cache_8way
// fully associative tag cache with least recently used replacement by stamp
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   request | in        | in_valid / in_ready  | op, key, handle
//   result  | out       | out_valid / out_ready| hit, slot, handle_out,
//           |           |                      | release_old
//
// lookup and insert make one sequential pass over the entry ram (one read
// and one compare per way, the compare lagging the registered read), then a
// write-back state, then a result state. clear and the unused op code go
// straight to the write-back state and then the result state.
// in_ready is high only in idle; a result waiting on out_ready does not
// block the next request, only the hand-off of that request's own result.
// rst is synchronous: all entries invalid, use counter zero, no result held.
// ----------------------------------------------------------------------------
module lru_tag_cache_8way
  import ltc_pkg::*;
#(
  parameter int unsigned WAYS     = 8,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned AGE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             op,
  input  wire logic [KEY_IN_BITS-1:0] key,
  input  wire logic [HANDLE_BITS-1:0] handle,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        hit,
  output logic [SLOT_BITS-1:0]        slot,
  output logic [HANDLE_BITS-1:0]      handle_out,
  output logic                        release_old
);

  localparam int unsigned IDX_W = $clog2(WAYS);
  localparam int unsigned CNT_W = $clog2(WAYS + 1);
  localparam int unsigned ENT_W = KEY_BITS + HANDLE_BITS + AGE_BITS;

  // ram word layout: key on top, handle in the middle, age stamp at the bottom

  state_t state;

  // latched request
  op_t                  req_op;
  logic [KEY_BITS-1:0]  req_key;
  logic [HANDLE_BITS-1:0] req_handle;

  // entry state kept in flops
  logic [WAYS-1:0]      valid;
  logic [AGE_BITS-1:0]  counter;

  // scan sequencing
  logic [CNT_W-1:0]     cnt;
  logic                 cmp_en;
  logic [IDX_W-1:0]     cmp_idx;

  // scan trackers
  logic                 match_found;
  logic [IDX_W-1:0]     match_idx;
  logic [HANDLE_BITS-1:0] match_handle;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [AGE_BITS-1:0]  min_age;
  logic [IDX_W-1:0]     min_idx;
  logic [HANDLE_BITS-1:0] min_handle;

  // pending result
  logic                 res_hit;
  logic [IDX_W-1:0]     res_slot;
  logic [HANDLE_BITS-1:0] res_handle;
  logic                 res_rel;

  // ram ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;

  logic [KEY_BITS-1:0]    ent_key;
  logic [HANDLE_BITS-1:0] ent_handle;
  logic [AGE_BITS-1:0]    ent_age;
  logic                   ent_valid;

  logic [AGE_BITS-1:0]    new_age;
  logic [IDX_W-1:0]       ins_idx;
  logic                   req_xfer;
  logic                   out_free;

  assign in_ready = (state == S_IDLE);
  assign req_xfer = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign ent_key    = ram_rdata[ENT_W-1 -: KEY_BITS];
  assign ent_handle = ram_rdata[AGE_BITS +: HANDLE_BITS];
  assign ent_age    = ram_rdata[AGE_BITS-1:0];
  assign ent_valid  = valid[cmp_idx];

  assign new_age = counter + AGE_BITS'(1);

  // insert target: present key, else first free way, else oldest stamp
  always_comb begin
    priority if (match_found) begin
      ins_idx = match_idx;
    end else if (free_found) begin
      ins_idx = free_idx;
    end else begin
      ins_idx = min_idx;
    end
  end

  // write-back: lookup keeps its handle and only restamps
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ins_idx;
    ram_wdata = {req_key, req_handle, new_age};
    if (state == S_WRITE) begin
      unique case (req_op)
        OP_LOOKUP: begin
          ram_we    = match_found;
          ram_waddr = match_idx;
          ram_wdata = {req_key, match_handle, new_age};
        end
        OP_INSERT: begin
          ram_we = 1'b1;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  ltc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (WAYS)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      counter <= '0;
      cnt     <= '0;
      cmp_en  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt    <= '0;
          cmp_en <= 1'b0;
          if (req_xfer) begin
            if (op == OP_LOOKUP || op == OP_INSERT) begin
              state <= S_SCAN;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_SCAN: begin
          // issue one read per cycle, each way is compared in the cycle after its read
          cmp_en <= (cnt != CNT_W'(WAYS));
          if (cnt == CNT_W'(WAYS)) begin
            state <= S_WRITE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_WRITE: begin
          cmp_en <= 1'b0;
          unique case (req_op)
            OP_LOOKUP: begin
              if (match_found) begin
                counter <= new_age;
              end
            end
            OP_INSERT: begin
              counter          <= new_age;
              valid[ins_idx]   <= 1'b1;
            end
            OP_CLEAR: begin
              counter <= '0;
              valid   <= '0;
            end
            default: begin
              counter <= counter;
            end
          endcase
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request latch, scan trackers and pending result
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_op      <= op_t'(op);
      req_key     <= KEY_BITS'(key);
      req_handle  <= handle;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end

    if (state == S_SCAN) begin
      cmp_idx <= cnt[IDX_W-1:0];
    end

    if (state == S_SCAN && cmp_en) begin
      if (!match_found && ent_valid && ent_key == req_key) begin
        match_found  <= 1'b1;
        match_idx    <= cmp_idx;
        match_handle <= ent_handle;
      end
      if (!free_found && !ent_valid) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      // strict compare keeps the lowest way on equal stamps
      if (cmp_idx == '0 || ent_age < min_age) begin
        min_age    <= ent_age;
        min_idx    <= cmp_idx;
        min_handle <= ent_handle;
      end
    end

    if (state == S_WRITE) begin
      res_hit    <= 1'b0;
      res_slot   <= '0;
      res_handle <= '0;
      res_rel    <= 1'b0;
      unique case (req_op)
        OP_LOOKUP: begin
          if (match_found) begin
            res_hit    <= 1'b1;
            res_slot   <= match_idx;
            res_handle <= match_handle;
          end
        end
        OP_INSERT: begin
          res_hit  <= match_found;
          res_slot <= ins_idx;
          res_rel  <= match_found || !free_found;
          priority if (match_found) begin
            res_handle <= match_handle;
          end else if (!free_found) begin
            res_handle <= min_handle;
          end
        end
        default: begin
          res_hit <= 1'b0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      hit         <= res_hit;
      slot        <= SLOT_BITS'(res_slot);
      handle_out  <= res_handle;
      release_old <= res_rel;
    end
  end

endmodule
`default_nettype wire

>>> dv/lru_tag_cache_8way_tb.sv
// ----------------------------------------------------------------------------
// lru_tag_cache_8way_tb
// self-checking bench for the eight-way lru tag cache
// ----------------------------------------------------------------------------
// drives lookup, insert, clear and the unused op code over the request
// channel. a cycle-free model of the cache is updated at every request
// transfer and queues the reply it implies. every result transfer is compared
// field by field with the oldest queued reply. a short directed pass covers
// empty and full cache behavior, refresh, update and eviction. random traffic
// over small key pools follows. both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module lru_tag_cache_8way_tb;
  import ltc_pkg::*;

  localparam int N_WAYS = 8;
  // op code with no operation behind it, outside the package enum
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles with no transfer on either channel before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // request transfer to out_valid for lookup and insert
  localparam int OP_LATENCY = N_WAYS + 3;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_BITS-1:0]   slot;
    logic [HANDLE_BITS-1:0] handle_out;
    logic                   release_old;
  } reply_t;

  // dut ports, inputs all known from time zero
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             op = OP_LOOKUP;
  logic [KEY_IN_BITS-1:0] key = '0;
  logic [HANDLE_BITS-1:0] handle = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   hit;
  logic [SLOT_BITS-1:0]   slot;
  logic [HANDLE_BITS-1:0] handle_out;
  logic                   release_old;

  // model of the cache contents
  logic [KEY_IN_BITS-1:0] way_key    [N_WAYS];
  logic [HANDLE_BITS-1:0] way_handle [N_WAYS];
  logic [31:0]            way_stamp  [N_WAYS];
  logic                   way_valid  [N_WAYS];
  logic [31:0]            stamp_count;

  // replies owed by the dut, oldest first
  reply_t pending_replies[$];

  // bench control
  bit idling_on = 1'b1;
  int error_count = 0;
  int quiet_cycles = 0;

  // what the run went through
  int n_requests = 0;
  int n_lookup_hits = 0;
  int n_lookup_misses = 0;
  int n_fills = 0;
  int n_evictions = 0;
  int n_updates = 0;
  int n_clears = 0;
  int n_unused = 0;

  lru_tag_cache_8way uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .key         (key),
    .handle      (handle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .slot        (slot),
    .handle_out  (handle_out),
    .release_old (release_old)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // cache model
  // ------------------------------------------------------------------

  function automatic void empty_cache();
    for (int i = 0; i < N_WAYS; i++) begin
      way_key[i]    = '0;
      way_handle[i] = '0;
      way_stamp[i]  = '0;
      way_valid[i]  = 1'b0;
    end
    stamp_count = '0;
  endfunction

  // first valid way holding the tag, -1 when absent
  function automatic int find_way(logic [KEY_IN_BITS-1:0] tag);
    for (int i = 0; i < N_WAYS; i++) begin
      if (way_valid[i] && way_key[i] == tag) return i;
    end
    return -1;
  endfunction

  // counter wraps at 32 bits, new value marks the way most recent
  function automatic void touch_way(int w);
    stamp_count  = stamp_count + 32'd1;
    way_stamp[w] = stamp_count;
  endfunction

  // applies one request to the model and returns the reply it causes
  function automatic reply_t apply_cache_op(logic [1:0] req_op,
                                            logic [KEY_IN_BITS-1:0] req_key,
                                            logic [HANDLE_BITS-1:0] req_handle);
    reply_t r;
    int w;
    r = '0;
    w = -1;
    n_requests++;
    if (req_op == OP_LOOKUP) begin
      w = find_way(req_key);
      if (w >= 0) begin
        touch_way(w);
        r.hit        = 1'b1;
        r.slot       = w[SLOT_BITS-1:0];
        r.handle_out = way_handle[w];
        n_lookup_hits++;
      end else begin
        n_lookup_misses++;
      end
    end else if (req_op == OP_INSERT) begin
      w = find_way(req_key);
      if (w >= 0) begin
        // tag already present: swap the handle, hand back the old one
        r.hit         = 1'b1;
        r.handle_out  = way_handle[w];
        r.release_old = 1'b1;
        n_updates++;
      end else begin
        for (int i = 0; i < N_WAYS; i++) begin
          if (!way_valid[i]) begin
            w = i;
            break;
          end
        end
        if (w < 0) begin
          // full: lowest stamp goes, lowest index on a tie
          w = 0;
          for (int i = 1; i < N_WAYS; i++) begin
            if (way_stamp[i] < way_stamp[w]) w = i;
          end
          r.handle_out  = way_handle[w];
          r.release_old = 1'b1;
          n_evictions++;
        end else begin
          n_fills++;
        end
        way_key[w]   = req_key;
        way_valid[w] = 1'b1;
      end
      way_handle[w] = req_handle;
      touch_way(w);
      r.slot = w[SLOT_BITS-1:0];
    end else if (req_op == OP_CLEAR) begin
      empty_cache();
      n_clears++;
    end else begin
      n_unused++;
    end
    return r;
  endfunction

  // ------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------

  // holds in_valid low for a random burst, starting at the next falling edge
  task automatic idle_sender();
    int gap;
    gap = $urandom_range(1, 6);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // one request transfer; the model is advanced at the accepting edge
  task automatic send_request(logic [1:0] req_op,
                              logic [KEY_IN_BITS-1:0] req_key,
                              logic [HANDLE_BITS-1:0] req_handle);
    if (idling_on && $urandom_range(0, 3) == 0) idle_sender();
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= req_op;
    key      <= req_key;
    handle   <= req_handle;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(apply_cache_op(req_op, req_key, req_handle));
  endtask

  // sender holds off until every owed reply has been seen
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------

  // out_ready stalls in random bursts; the quiet tail keeps it high
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each result transfer with the oldest owed reply
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("result transfer with no request outstanding: hit %0d slot %0d",
               hit, slot);
        error_count++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (hit !== exp_r.hit) begin
          $error("hit expected %0h actual %0h", exp_r.hit, hit);
          error_count++;
        end
        if (slot !== exp_r.slot) begin
          $error("slot expected %0h actual %0h", exp_r.slot, slot);
          error_count++;
        end
        if (handle_out !== exp_r.handle_out) begin
          $error("handle_out expected %0h actual %0h", exp_r.handle_out, handle_out);
          error_count++;
        end
        if (release_old !== exp_r.release_old) begin
          $error("release_old expected %0h actual %0h", exp_r.release_old,
                 release_old);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // hang detection
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < HANG_LIMIT) @(posedge clk);
    $display("no transfer for %0d cycles, %0d replies still owed", HANG_LIMIT,
             pending_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // empty cache: the model's tags are zero but invalid, so key 0 must miss
  task automatic test_empty_cache();
    send_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // fill all ways in order, then refresh two of them
  task automatic test_fill_ways();
    send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 32'h0000_0001, $urandom);
    send_request(OP_INSERT, 32'h8000_0000, $urandom);
    send_request(OP_INSERT, 32'h7FFF_FFFF, $urandom);
    send_request(OP_INSERT, 32'h0000_0002, $urandom);
    // way 0 becomes most recent, so way 1 is now the oldest
    send_request(OP_LOOKUP, 32'h0000_0000, $urandom);
    send_request(OP_LOOKUP, 32'h0000_0002, $urandom);
  endtask

  // present-key update, then two evictions picked by stamp order
  task automatic test_update_and_evict();
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h1234_5678, 32'h0BAD_F00D);
    send_request(OP_LOOKUP, 32'hAAAA_AAAA, $urandom);
    send_request(OP_INSERT, 32'h8765_4321, 32'h0000_0000);
  endtask

  // unused op on a full cache leaves it alone; clear then empties it
  task automatic test_clear_and_unused();
    send_request(OP_UNUSED, 32'h1234_5678, $urandom);
    send_request(OP_LOOKUP, 32'h1234_5678, $urandom);
    send_request(OP_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h1234_5678, $urandom);
    send_request(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  // random traffic over a small key pool so hits, updates and evictions
  // all stay frequent; a few fully random keys, rare unused ops and clears mixed in
  task automatic test_random_traffic(int count, int pool_size);
    logic [KEY_IN_BITS-1:0] key_pool[$];
    logic [KEY_IN_BITS-1:0] k;
    logic [1:0] o;
    int pick;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 47) o = OP_LOOKUP;
      else if (pick < 94) o = OP_INSERT;
      else if (pick < 97) o = OP_UNUSED;
      else o = OP_CLEAR;
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
      else k = $urandom;
      send_request(o, k, $urandom);
    end
  endtask

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------

  initial begin
    empty_cache();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_cache();
    test_fill_ways();
    test_update_and_evict();
    test_clear_and_unused();
    // let the cache settle completely before random traffic starts
    wait_for_drain();

    test_random_traffic(350, 6);
    wait_for_drain();
    test_random_traffic(350, 10);
    test_random_traffic(300, 14);
    wait_for_drain();
    test_random_traffic(200, 9);
    // back-to-back tail with no idling on either side
    idling_on = 1'b0;
    test_random_traffic(250, 8);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * OP_LATENCY) @(posedge clk);

    $display("covered %0d requests: %0d lookup hits, %0d lookup misses, %0d clears",
             n_requests, n_lookup_hits, n_lookup_misses, n_clears);
    $display("inserts: %0d into free ways, %0d evictions, %0d updates; %0d unused ops",
             n_fills, n_evictions, n_updates, n_unused);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
